// ===== rtl/dalitx_pkg.sv =====
// Shared constants, codes and types for the DALI forward frame transmitter.
`default_nettype none

package dalitx_pkg;

  // Frame width
  localparam int FRAME_BITS_DEF = 16;
  localparam int BITS_LEFT_W    = 5;

  // Register reset values
  localparam logic [15:0] HALF_BIT_RST   = 16'd1389;
  localparam logic [15:0] STOP_RST       = 16'd5556;
  localparam logic [9:0]  GUARD_RST      = 10'd33;
  localparam logic [7:0]  START_TRIM_RST = 8'd5;

  // Register indexes (word address)
  localparam logic [1:0] REG_HALF_BIT   = 2'd0;
  localparam logic [1:0] REG_STOP       = 2'd1;
  localparam logic [1:0] REG_GUARD      = 2'd2;
  localparam logic [1:0] REG_START_TRIM = 2'd3;

  // Frame phases
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_ACCEPTED  = 3'd1;
  localparam logic [2:0] ST_SENDING   = 3'd2;
  localparam logic [2:0] ST_BUS_BUSY  = 3'd3;
  localparam logic [2:0] ST_COLLISION = 3'd4;

  // Position within the frame, apart from the data shifter
  typedef struct packed {
    logic [1:0]             phase;
    logic                   pending_half;
    logic [BITS_LEFT_W-1:0] bits_left;
  } cursor_t;

  // Outcome of stepping to the next interval
  typedef struct packed {
    logic        ok;
    logic        level;
    logic [15:0] length;
  } step_t;

endpackage : dalitx_pkg

`default_nettype wire

// ===== rtl/dali_forward_frame_transmitter_unit.sv =====
// Top level of the DALI forward frame transmitter: stream ports, registers, tick engine.
`default_nettype none

// A result word is registered and appears on out_* in the cycle after its input word is accepted.
// Throughput: one word per cycle; in_tready stays high while the output register is
//   empty or being drained, so ticks and requests stream back to back.
// Every word (tick or send request) yields exactly one result word.
// Reset (synchronous, rst_n low): idle, bus released, output register empty,
//   registers back to 1389 / 5556 / 33 / 5 ticks.
module dali_forward_frame_transmitter_unit #(
  parameter int FRAME_BITS = dalitx_pkg::FRAME_BITS_DEF
) (
  input  var logic        clk,
  input  var logic        rst_n,
  // Input stream
  input  var logic        in_tvalid,
  output logic            in_tready,
  input  var logic [23:0] in_tdata,   // [7:0] address_byte, [15:8] command_byte,
                                      // [16] bus_shorted, [23:17] zero
  input  var logic        in_tuser,   // [0] cmd: 0 tick, 1 send request
  // Result stream
  output logic            out_tvalid,
  input  var logic        out_tready,
  output logic [7:0]      out_tdata,  // [0] line_drive, [1] busy_res, [4:2] status,
                                      // [5] frame_done, [7:6] zero
  // Configuration port
  input  var logic        cfg_psel,
  input  var logic        cfg_penable,
  input  var logic        cfg_pwrite,
  input  var logic [3:0]  cfg_paddr,
  input  var logic [31:0] cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);
  import dalitx_pkg::*;

  localparam int WIDE_W = (FRAME_BITS > 16) ? FRAME_BITS : 16;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] half_bit_r;
  logic [15:0] stop_r;
  logic [9:0]  guard_r;
  logic [7:0]  trim_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_r <= HALF_BIT_RST;
      stop_r     <= STOP_RST;
      guard_r    <= GUARD_RST;
      trim_r     <= START_TRIM_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_HALF_BIT:   half_bit_r <= cfg_pwdata[15:0];
        REG_STOP:       stop_r     <= cfg_pwdata[15:0];
        REG_GUARD:      guard_r    <= cfg_pwdata[9:0];
        REG_START_TRIM: trim_r     <= cfg_pwdata[7:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_HALF_BIT:   cfg_prdata = {16'd0, half_bit_r};
      REG_STOP:       cfg_prdata = {16'd0, stop_r};
      REG_GUARD:      cfg_prdata = {22'd0, guard_r};
      REG_START_TRIM: cfg_prdata = {24'd0, trim_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  cursor_t               cur_r, cur_nxt;
  logic [FRAME_BITS-1:0] shift_r, shift_nxt;
  logic [15:0]           ic_r, ic_nxt;       // ticks left in the current interval
  logic                  drive_r, drive_nxt;
  logic                  sending_r, sending_nxt;

  // Output register: the skid point between the two sides
  logic                  out_valid_r;
  logic [7:0]            out_data_r;

  // Per-word fields
  logic                  in_acc;
  logic                  w_cmd;
  logic                  w_shorted;
  logic [15:0]           w_frame16;
  logic [WIDE_W-1:0]     w_wide;

  // Next-interval view, shared by the guard look-ahead and the real advance
  cursor_t               adv_cur;
  logic [FRAME_BITS-1:0] adv_shift;
  step_t                 adv;

  logic [15:0]           hb_eff;
  logic [16:0]           remaining;
  logic                  abort;
  logic [15:0]           ic_dec;
  logic [2:0]            status;
  logic                  done;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;
  assign w_cmd     = in_tuser;
  assign w_shorted = in_tdata[16];
  assign w_frame16 = {in_tdata[7:0], in_tdata[15:8]};  // address byte leads
  assign w_wide    = WIDE_W'(w_frame16);

  dalitx_cursor #(
    .FRAME_BITS(FRAME_BITS)
  ) u_cursor (
    .cur_i           (cur_r),
    .shift_i         (shift_r),
    .half_bit_ticks_i(half_bit_r),
    .stop_ticks_i    (stop_r),
    .cur_o           (adv_cur),
    .shift_o         (adv_shift),
    .step_o          (adv)
  );

  always_comb begin
    cur_nxt     = cur_r;
    shift_nxt   = shift_r;
    ic_nxt      = ic_r;
    drive_nxt   = drive_r;
    sending_nxt = sending_r;
    status      = ST_NONE;
    done        = 1'b0;

    hb_eff = (half_bit_r == '0) ? 16'd1 : half_bit_r;

    // Released ticks left in this run, including a following released half bit
    remaining = 17'(ic_r) + ((adv.ok && !adv.level) ? 17'(adv.length) : 17'd0);
    abort     = ~drive_r & w_shorted & (remaining == 17'(guard_r));

    ic_dec = (ic_r != '0) ? ic_r - 16'd1 : ic_r;

    if (w_cmd) begin
      if (sending_r) begin
        status = ST_SENDING;
      end else if (w_shorted) begin
        status = ST_BUS_BUSY;
      end else begin
        cur_nxt.phase        = PH_START;
        cur_nxt.pending_half = 1'b0;
        cur_nxt.bits_left    = BITS_LEFT_W'(FRAME_BITS);
        shift_nxt            = w_wide[FRAME_BITS-1:0];
        // Trimmed first half bit, never shorter than one tick
        ic_nxt      = (hb_eff > 16'(trim_r)) ? hb_eff - 16'(trim_r) : 16'd1;
        drive_nxt   = 1'b1;
        sending_nxt = 1'b1;
        status      = ST_ACCEPTED;
      end
    end else if (sending_r) begin
      if (abort) begin
        sending_nxt = 1'b0;
        drive_nxt   = 1'b0;
        ic_nxt      = '0;
        status      = ST_COLLISION;
      end else begin
        ic_nxt = ic_dec;
        if (ic_dec == '0) begin
          if (adv.ok) begin
            cur_nxt   = adv_cur;
            shift_nxt = adv_shift;
            ic_nxt    = adv.length;
            drive_nxt = adv.level;
          end else begin
            // stop time over: frame complete
            sending_nxt = 1'b0;
            drive_nxt   = 1'b0;
            done        = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '{phase: PH_START, pending_half: 1'b0, bits_left: '0};
      shift_r     <= '0;
      ic_r        <= '0;
      drive_r     <= 1'b0;
      sending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cur_r     <= cur_nxt;
        shift_r   <= shift_nxt;
        ic_r      <= ic_nxt;
        drive_r   <= drive_nxt;
        sending_r <= sending_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {2'b00, done, status, sending_nxt, drive_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> !drive_r)
    else $error("bus driven while idle");

  a_interval_live: assert property (@(posedge clk) disable iff (!rst_n)
    sending_r |-> ic_r != '0)
    else $error("empty interval while sending");

  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && w_cmd && !sending_r && !w_shorted) |=> (sending_r && drive_r))
    else $error("accepted request did not start a frame");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[5]) |-> (!out_data_r[1] && !out_data_r[0]
                                        && out_data_r[4:2] == ST_NONE))
    else $error("frame done while still busy");

  a_collision_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[4:2] == ST_COLLISION) |-> (!out_data_r[1] && !out_data_r[0]))
    else $error("collision left the frame running");

endmodule : dali_forward_frame_transmitter_unit

`default_nettype wire

// ===== rtl/dalitx_cursor.sv =====
// Next-interval logic: steps the frame cursor one half bit and gives its level and length.
`default_nettype none

module dalitx_cursor #(
  parameter int FRAME_BITS = dalitx_pkg::FRAME_BITS_DEF
) (
  input  var dalitx_pkg::cursor_t  cur_i,
  input  var logic [FRAME_BITS-1:0] shift_i,
  input  var logic [15:0]           half_bit_ticks_i,
  input  var logic [15:0]           stop_ticks_i,
  output dalitx_pkg::cursor_t       cur_o,
  output logic [FRAME_BITS-1:0]     shift_o,
  output dalitx_pkg::step_t         step_o
);
  import dalitx_pkg::*;

  logic [BITS_LEFT_W-1:0] bl_dec;
  logic [15:0]            raw_len;

  always_comb begin
    cur_o   = cur_i;
    shift_o = shift_i;
    step_o  = '0;
    bl_dec  = cur_i.bits_left;
    if (cur_i.bits_left != '0) begin
      bl_dec = cur_i.bits_left - BITS_LEFT_W'(1);
    end

    if (cur_i.phase[1]) begin
      step_o.ok = 1'b0;  // stop time was the last interval
    end else if (!cur_i.pending_half) begin
      step_o.ok          = 1'b1;
      cur_o.pending_half = 1'b1;
    end else begin
      step_o.ok          = 1'b1;
      cur_o.pending_half = 1'b0;
      if (cur_i.phase == PH_START) begin
        cur_o.phase = (cur_i.bits_left == '0) ? PH_STOP : PH_DATA;
      end else begin
        shift_o         = {shift_i[FRAME_BITS-2:0], 1'b0};
        cur_o.bits_left = bl_dec;
        if (bl_dec == '0) begin
          cur_o.phase = PH_STOP;
        end
      end
    end

    // Level of the new half bit: a 1 bit is driven then released
    case (cur_o.phase)
      PH_START: step_o.level = ~cur_o.pending_half;
      PH_DATA:  step_o.level = shift_o[FRAME_BITS-1] ^ cur_o.pending_half;
      default:  step_o.level = 1'b0;
    endcase

    raw_len       = cur_o.phase[1] ? stop_ticks_i : half_bit_ticks_i;
    step_o.length = (raw_len == '0) ? 16'd1 : raw_len;
  end

endmodule : dalitx_cursor

`default_nettype wire

// ===== tb/sv/tb_dali_forward_frame_transmitter_unit.sv =====
// Self-checking testbench for the DALI forward frame transmitter unit.
module tb_dali_forward_frame_transmitter_unit;
  import dalitx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;  // generous: well above the slowest run
  localparam int LONG_HOLD   = 120;     // receiver back-pressure stretch, in cycles
  localparam int RANDOM_WORDS = 1350;

  // One input word: tick or send request plus the sampled bus level
  typedef struct packed {
    logic       send;
    logic [7:0] addr;
    logic [7:0] cbyte;
    logic       shorted;
  } tx_word_t;

  // One result word
  typedef struct packed {
    logic       drive;
    logic       busy;
    logic [2:0] status;
    logic       done;
  } tx_result_t;

  // Where the transmitter is inside the frame
  typedef struct packed {
    logic [1:0]  phase;
    logic        second;  // 0 = first half of a bit, 1 = second half
    logic [15:0] shift;
    logic [4:0]  bits;
  } tx_pos_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;  // [7:0] address_byte, [15:8] command_byte, [16] bus_shorted
  logic        in_tuser = 1'b0;  // [0] cmd: 0 tick, 1 send request
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;  // [0] line_drive, [1] busy_res, [4:2] status, [5] frame_done
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dali_forward_frame_transmitter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Words waiting for the driver, and results the line should produce
  tx_word_t   words_pending[$];
  tx_result_t line_results_due[$];
  int words_queued = 0;
  int words_taken = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // Idling control, set per phase by the stimulus process
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  int hold_asked = 0;
  int hold_served = 0;
  int src_gap = 0;
  int sink_gap = 0;

  // Local copy of the registers
  logic [15:0] cfg_half = HALF_BIT_RST;
  logic [15:0] cfg_stop = STOP_RST;
  logic [9:0]  cfg_guard = GUARD_RST;
  logic [7:0]  cfg_trim = START_TRIM_RST;

  // Local copy of the transmitter state
  tx_pos_t tx_pos = '{phase: PH_START, second: 1'b0, shift: 16'h0, bits: 5'd0};
  int      tx_count = 0;
  logic    tx_drive = 1'b0;
  logic    tx_sending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line waveform predictor
  // ---------------------------------------------------------------------------

  // Bus level of the half bit at p (1 = driven)
  function automatic logic pos_level(tx_pos_t p);
    if (p.phase == PH_START) return ~p.second;
    if (p.phase != PH_DATA) return 1'b0;
    return p.shift[15] ^ p.second;
  endfunction

  // Ticks in the interval at p; zero-length settings count as one tick
  function automatic int pos_length(tx_pos_t p);
    int v;
    v = (p.phase == PH_STOP) ? int'(cfg_stop) : int'(cfg_half);
    return (v == 0) ? 1 : v;
  endfunction

  // Step to the next half bit; 0 when the stop time was the last interval
  function automatic bit pos_advance(inout tx_pos_t p);
    if (p.phase == PH_STOP) return 1'b0;
    if (!p.second) begin
      p.second = 1'b1;
      return 1'b1;
    end
    p.second = 1'b0;
    if (p.phase == PH_START) begin
      p.phase = (p.bits == 5'd0) ? PH_STOP : PH_DATA;
      return 1'b1;
    end
    p.shift = p.shift << 1;
    if (p.bits > 5'd0) p.bits = p.bits - 5'd1;
    if (p.bits == 5'd0) p.phase = PH_STOP;
    return 1'b1;
  endfunction

  // Applies one accepted word to the local state and returns the result word
  function automatic tx_result_t next_line_state(tx_word_t w);
    tx_result_t r;
    tx_pos_t    peek;
    int         remaining;
    int         hb;
    bit         more;
    bit         abort;
    r.status = ST_NONE;
    r.done = 1'b0;
    if (w.send) begin
      if (tx_sending) begin
        r.status = ST_SENDING;
      end else if (w.shorted) begin
        r.status = ST_BUS_BUSY;
      end else begin
        hb = (cfg_half == 0) ? 1 : int'(cfg_half);
        tx_pos = '{phase: PH_START, second: 1'b0, shift: {w.addr, w.cbyte}, bits: 5'd16};
        tx_count = (hb > int'(cfg_trim)) ? hb - int'(cfg_trim) : 1;  // trim floors at 1 tick
        tx_drive = 1'b1;
        tx_sending = 1'b1;
        r.status = ST_ACCEPTED;
      end
    end else if (tx_sending) begin
      abort = 1'b0;
      // released run: sample guard ticks before it ends, run may span into next half
      if (!tx_drive) begin
        remaining = tx_count;
        peek = tx_pos;
        more = pos_advance(peek);
        if (more && !pos_level(peek)) remaining += pos_length(peek);
        abort = (remaining == int'(cfg_guard)) && w.shorted;
      end
      if (abort) begin
        tx_sending = 1'b0;
        tx_drive = 1'b0;
        tx_count = 0;
        r.status = ST_COLLISION;
      end else begin
        if (tx_count > 0) tx_count--;
        if (tx_count == 0) begin
          if (pos_advance(tx_pos)) begin
            tx_count = pos_length(tx_pos);
            tx_drive = pos_level(tx_pos);
          end else begin
            tx_sending = 1'b0;
            tx_drive = 1'b0;
            r.done = 1'b1;
          end
        end
      end
    end
    r.drive = tx_drive;
    r.busy = tx_sending;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one word from the pending queue per handshake, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    int       gap;
    logic     fire;
    tx_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
      src_gap <= 0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) gap = src_idle ? $urandom_range(0, 14) : 0;
      else gap = src_gap;
      if (in_tvalid && !fire) begin
        // word still offered: hold it
      end else if (gap == 0 && words_pending.size() != 0) begin
        w = words_pending.pop_front();
        in_tdata <= {7'd0, w.shorted, w.cbyte, w.addr};
        in_tuser <= w.send;
        in_tvalid <= 1'b1;
        src_gap <= 0;
      end else begin
        in_tvalid <= 1'b0;
        src_gap <= (gap == 0) ? 0 : gap - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus a long hold-off when asked
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ready
    int hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_gap <= 0;
    end else if (out_tvalid && out_tready) begin
      hold = sink_idle ? $urandom_range(0, 14) : 0;
      if (hold_served != hold_asked) begin
        hold = LONG_HOLD;
        hold_served <= hold_served + 1;
      end
      if (hold == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        sink_gap <= hold - 1;
      end
    end else if (!out_tready) begin
      if (sink_gap == 0) out_tready <= 1'b1;
      else sink_gap <= sink_gap - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results leaving, then predict for words entering
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_words
    tx_result_t want;
    tx_result_t got;
    tx_word_t   w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.drive = out_tdata[0];
        got.busy = out_tdata[1];
        got.status = out_tdata[4:2];
        got.done = out_tdata[5];
        if (line_results_due.size() == 0) begin
          $error("result word with none expected: %h", out_tdata);
          mismatches++;
        end else begin
          want = line_results_due.pop_front();
          if (got.drive !== want.drive) begin
            $error("line_drive: expected %0d, got %0d", want.drive, got.drive);
            mismatches++;
          end
          if (got.busy !== want.busy) begin
            $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.done !== want.done) begin
            $error("frame_done: expected %0d, got %0d", want.done, got.done);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        w.send = in_tuser;
        w.addr = in_tdata[7:0];
        w.cbyte = in_tdata[15:8];
        w.shorted = in_tdata[16];
        line_results_due.push_back(next_line_state(w));
        words_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_word(bit send, logic [7:0] a, logic [7:0] c, bit sh);
    tx_word_t w;
    w = '{send: send, addr: a, cbyte: c, shorted: sh};
    words_pending.push_back(w);
    words_queued++;
  endtask

  // Wait until every queued word went in and its result came back
  task automatic drain();
    while (words_taken != words_queued || line_results_due.size() != 0) @(posedge clk);
  endtask

  // Let any frame in flight run out so registers change on an idle line
  task automatic settle();
    drain();
    while (tx_sending) begin
      repeat (8) queue_word(1'b0, 8'h00, 8'h00, 1'b0);
      drain();
    end
    repeat (3) @(posedge clk);
  endtask

  // Register write: setup cycle, then access until pready
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_HALF_BIT:   cfg_half = val[15:0];
      REG_STOP:       cfg_stop = val[15:0];
      REG_GUARD:      cfg_guard = val[9:0];
      REG_START_TRIM: cfg_trim = val[7:0];
      default: ;
    endcase
  endtask

  // A send request followed by roughly a frame's worth of ticks. short_odds = 0
  // keeps the bus clean on the ticks, else about one tick in short_odds sees it shorted.
  task automatic queue_frame(int short_odds);
    int span;
    span = 34 * ((cfg_half == 0) ? 1 : int'(cfg_half))
         + ((cfg_stop == 0) ? 1 : int'(cfg_stop)) + $urandom_range(0, 4);
    queue_word(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               $urandom_range(0, 9) == 0);
    repeat (span) begin
      if ($urandom_range(0, 24) == 0)
        queue_word(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      else
        queue_word(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   short_odds != 0 && $urandom_range(1, short_odds) == 1);
    end
  endtask

  initial begin : stimulus
    int phase_no;
    int h;
    phase_no = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, refusals and idle ticks only
    queue_word(1'b0, 8'h00, 8'h00, 1'b0);
    queue_word(1'b0, 8'hFF, 8'hFF, 1'b1);
    queue_word(1'b1, 8'hFF, 8'hFF, 1'b1);  // bus held low at start: refused
    settle();

    // Trim larger than a half bit (first interval 1 tick), zero stop, guard 1
    write_reg(REG_HALF_BIT, 2);
    write_reg(REG_STOP, 0);
    write_reg(REG_GUARD, 1);
    write_reg(REG_START_TRIM, 255);
    queue_word(1'b1, 8'hFF, 8'h00, 1'b0);
    queue_word(1'b1, 8'h0F, 8'hF0, 1'b0);  // request while sending
    repeat (6) queue_word(1'b0, 8'h00, 8'h00, 1'b1);  // collides in start bit release
    // leading 0 merges start release with the next half: sampled at the run's end
    queue_word(1'b1, 8'h00, 8'hFF, 1'b0);
    repeat (8) queue_word(1'b0, 8'h00, 8'h00, 1'b1);
    repeat (2) queue_word(1'b0, 8'h00, 8'h00, 1'b0);

    // Random phases, each on its own register setting
    while (words_queued < RANDOM_WORDS) begin
      phase_no++;
      settle();
      if (phase_no == 1) begin
        // all-zero setting: every length floors at one tick, guard never samples
        write_reg(REG_HALF_BIT, 0);
        write_reg(REG_STOP, 0);
        write_reg(REG_GUARD, 0);
        write_reg(REG_START_TRIM, 0);
      end else if (phase_no == 2) begin
        // top of every range; a frame would take millions of ticks, so refusals only
        write_reg(REG_HALF_BIT, 32'hFFFF);
        write_reg(REG_STOP, 32'hFFFF);
        write_reg(REG_GUARD, 32'h3FF);
        write_reg(REG_START_TRIM, 32'hFF);
      end else begin
        h = $urandom_range(0, 3);
        write_reg(REG_HALF_BIT, h);
        write_reg(REG_STOP, $urandom_range(0, 6));
        write_reg(REG_GUARD, ($urandom_range(0, 5) == 0) ? 1023 : $urandom_range(0, 2 * h + 3));
        write_reg(REG_START_TRIM, ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 3));
      end
      src_idle <= $urandom_range(0, 2) != 0;
      sink_idle <= $urandom_range(0, 2) != 0;
      if (phase_no == 3) hold_asked <= hold_asked + 1;  // receiver backs off, input fills

      if (phase_no == 2) begin
        repeat (12) begin
          if ($urandom_range(0, 1))
            queue_word(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
          else
            queue_word(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        end
      end else begin
        repeat (2) queue_frame($urandom_range(0, 1) ? 0 : $urandom_range(2, 6));
        // stray words of any kind
        repeat ($urandom_range(0, 5))
          queue_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      drain();  // sender pauses until every result is back
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
